@@ sv/pie_pkg.sv @@
`timescale 1ns / 1ps

package pie_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int CNT_OUT_W = 7;
  localparam int STAT_W = 2;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // common width for position and count compares
  localparam int PCW   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read-out tree grouping
  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [VAL_W-1:0]      val_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ERASE,
    OP_READ
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t         op;
    logic [PCW-1:0]   pos;
    word_t            value;
  } cell_ctl_t;

endpackage

@@ sv/pie_cell.sv @@
`timescale 1ns / 1ps

module pie_cell (
  input  logic               clk,
  input  pie_pkg::cell_ctl_t ctl,
  input  logic [pie_pkg::IDX_W-1:0] idx,
  input  pie_pkg::word_t     left_data,
  input  pie_pkg::word_t     right_data,
  output pie_pkg::word_t     data,
  output pie_pkg::word_t     rd_word
);

  pie_pkg::word_t data_r, data_nxt;
  pie_pkg::word_t rd_r, rd_nxt;
  logic [pie_pkg::PCW-1:0] idx_e;

  assign idx_e = pie_pkg::PCW'(idx);

  always_comb begin
    data_nxt = data_r;
    rd_nxt   = '0;
    case (ctl.op)
      pie_pkg::OP_INSERT: begin
        if (idx_e > ctl.pos) begin
          data_nxt = left_data;
        end else if (idx_e == ctl.pos) begin
          data_nxt = ctl.value;
        end
      end
      pie_pkg::OP_ERASE: begin
        if (idx_e >= ctl.pos) begin
          data_nxt = right_data;
        end
      end
      pie_pkg::OP_READ: begin
        if (idx_e == ctl.pos) begin
          rd_nxt = data_r;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data    = data_r;
  assign rd_word = rd_r;

endmodule

@@ sv/pie_read_tree.sv @@
`timescale 1ns / 1ps

module pie_read_tree (
  input  logic           clk,
  input  pie_pkg::word_t rd_words [pie_pkg::CAPACITY],
  output pie_pkg::word_t rd_word
);

  pie_pkg::word_t grp_r   [pie_pkg::NGRP];
  pie_pkg::word_t grp_nxt [pie_pkg::NGRP];
  pie_pkg::word_t acc;

  // first level: or within groups of eight, registered
  always_comb begin
    for (int g = 0; g < pie_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < pie_pkg::GRP; k++) begin
        if (g * pie_pkg::GRP + k < pie_pkg::CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | rd_words[g * pie_pkg::GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < pie_pkg::NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // second level: or of the group results
  always_comb begin
    acc = '0;
    for (int g = 0; g < pie_pkg::NGRP; g++) begin
      acc = acc | grp_r[g];
    end
  end

  assign rd_word = acc;

endmodule

@@ sv/positional_insert_erase_list.sv @@
`timescale 1ns / 1ps

// ordered list of signed words held in a row of cells
// input channel: in_valid/in_ready carrying in_cmd, in_pos, in_value
//   insert at pos, erase at pos, read at pos, or clear the list
// result channel: out_valid/out_ready carrying out_read_value, out_count,
//   out_status; exactly one result word per command word
// insert, erase and clear: an accepted valid insert or erase shifts the whole
//   row in the accepting cycle; the result is registered at that edge
// read: the addressed cell drives a two-level or tree, and the result passes
//   the cell register, group register and output register in that order
// throughput: one command per cycle for insert, erase and clear while the
//   result is taken at once; a read is not overlapped with any other command
// in_ready is high only while no read is in flight and the output register
//   is empty or being taken, so a stalled receiver holds off new commands
// reset empties the list (count zero) and drops any pending result; cell
//   contents are left as they are and are only read below count

module positional_insert_erase_list (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pie_pkg::CMD_W-1:0]      in_cmd,
  input  logic [pie_pkg::POS_W-1:0]      in_pos,
  input  logic signed [pie_pkg::VAL_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pie_pkg::VAL_W-1:0] out_read_value,
  output logic [pie_pkg::CNT_OUT_W-1:0]  out_count,
  output logic [pie_pkg::STAT_W-1:0]     out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2
  } state_t;

  state_t state_r;

  logic [pie_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  pie_pkg::status_t          stat_nxt, stat_r;
  pie_pkg::cell_op_t         op_nxt;
  pie_pkg::cell_ctl_t        ctl;

  logic                        out_valid_r;
  pie_pkg::val_t               out_read_value_r;
  logic [pie_pkg::CNT_OUT_W-1:0] out_count_r;
  pie_pkg::status_t            out_status_r;

  logic fire;
  logic [pie_pkg::PCW-1:0] pos_e, cnt_e;
  pie_pkg::cmd_t cmd;

  pie_pkg::word_t cell_data [pie_pkg::CAPACITY];
  pie_pkg::word_t cell_rd   [pie_pkg::CAPACITY];
  pie_pkg::word_t tree_word;

  // handshake, held off while in reset
  assign in_ready = rst_n && (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign fire     = in_valid && in_ready;

  assign cmd   = pie_pkg::cmd_t'(in_cmd);
  assign pos_e = pie_pkg::PCW'(in_pos);
  assign cnt_e = pie_pkg::PCW'(cnt_r);

  // command decode: position check first, then full check
  always_comb begin
    cnt_nxt  = cnt_r;
    stat_nxt = pie_pkg::ST_OK;
    op_nxt   = pie_pkg::OP_HOLD;
    case (cmd)
      pie_pkg::CMD_INSERT: begin
        if (pos_e > cnt_e) begin
          stat_nxt = pie_pkg::ST_BADPOS;
        end else if (cnt_e == pie_pkg::PCW'(pie_pkg::CAPACITY)) begin
          stat_nxt = pie_pkg::ST_FULL;
        end else begin
          op_nxt  = pie_pkg::OP_INSERT;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pie_pkg::CMD_ERASE: begin
        if (pos_e >= cnt_e) begin
          stat_nxt = pie_pkg::ST_BADPOS;
        end else begin
          op_nxt  = pie_pkg::OP_ERASE;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      pie_pkg::CMD_READ: begin
        // bad reads still run the tree, no cell answers so the word is zero
        if (pos_e >= cnt_e) begin
          stat_nxt = pie_pkg::ST_BADPOS;
        end else begin
          op_nxt = pie_pkg::OP_READ;
        end
      end
      pie_pkg::CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // broadcast to the row only on an accepted word
  assign ctl.op    = fire ? op_nxt : pie_pkg::OP_HOLD;
  assign ctl.pos   = pos_e;
  assign ctl.value = pie_pkg::word_t'(in_value);

  // row of cells, each linked to its neighbours, zero fed in past both ends
  for (genvar i = 0; i < pie_pkg::CAPACITY; i++) begin : g_cell
    pie_pkg::word_t left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == pie_pkg::CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pie_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (pie_pkg::IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_word    (cell_rd[i])
    );
  end

  pie_read_tree u_tree (
    .clk      (clk),
    .rd_words (cell_rd),
    .rd_word  (tree_word)
  );

  // control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (fire) begin
            cnt_r  <= cnt_nxt;
            stat_r <= stat_nxt;
            if (cmd == pie_pkg::CMD_READ) begin
              // any pending word is taken in this same cycle
              state_r     <= S_RD1;
              out_valid_r <= 1'b0;
            end else begin
              out_valid_r      <= 1'b1;
              out_read_value_r <= '0;
              out_count_r      <= pie_pkg::CNT_OUT_W'(cnt_nxt);
              out_status_r     <= stat_nxt;
            end
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_RD1: begin
          state_r <= S_RD2;
        end
        S_RD2: begin
          state_r          <= S_IDLE;
          out_valid_r      <= 1'b1;
          out_read_value_r <= pie_pkg::val_t'(tree_word);
          out_count_r      <= pie_pkg::CNT_OUT_W'(cnt_r);
          out_status_r     <= stat_r;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  // count never runs past the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pie_pkg::PCW'(cnt_r) <= pie_pkg::PCW'(pie_pkg::CAPACITY))
    else $error("list count above capacity");

  // insert into a full list leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd == pie_pkg::CMD_INSERT &&
     cnt_e == pie_pkg::PCW'(pie_pkg::CAPACITY)) |=> $stable(cnt_r))
    else $error("count changed on insert into full list");

  // clear gives an ok result with empty count on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd == pie_pkg::CMD_CLEAR) |=>
      (out_valid && out_count == '0 && out_status == pie_pkg::ST_OK))
    else $error("clear result wrong");

  // no new word while a read is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready during read");

  // after acceptance a read steps through S_RD1 into S_RD2
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cmd == pie_pkg::CMD_READ) |=> ##1 (state_r == S_RD2))
    else $error("read pipeline out of step");

endmodule
